// ===== rtl/ptg_pkg.sv =====
`default_nettype none
package ptg_pkg;

	localparam int DIM_BITS_DEF = 20;
	localparam int Q_DEPTH_DEF  = 4;

	localparam int TILE_W_BITS = 13;
	localparam int RES_W       = 5;
	localparam int ZOOM_W      = 5;
	localparam int IDX_W       = 32;
	localparam int POS_W       = 22;
	localparam int ST_W        = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 80;
	localparam int M_PAD_W   = M_TDATA_W - (2 * TILE_W_BITS + 2 * POS_W + ZOOM_W);

	localparam logic [TILE_W_BITS-1:0] TILE_RESET = 13'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_TILE_W       = 3'd2,
		REG_TILE_H       = 3'd3,
		REG_ORIGIN_X     = 3'd4,
		REG_ORIGIN_Y     = 3'd5
	} reg_idx_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_BAD_RES  = 2'd1,
		ST_BAD_TILE = 2'd2
	} status_t;

endpackage
`default_nettype wire

// ===== rtl/ptg_div.sv =====
`default_nettype none
module ptg_div
	import ptg_pkg::*;
#(
	parameter int N = IDX_W,
	parameter int D = TILE_W_BITS
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [N-1:0] dividend,
	input  wire logic [D-1:0] divisor,
	output logic      [N-1:0] quo,
	output logic      [D-1:0] rem
);

	// restoring divider, one quotient bit per stage, MSB first
	logic [D-1:0] rem_s [N];
	logic [N-1:0] acc_s [N];
	logic [D-1:0] dvs_s [N];

	logic [D-1:0] rem_in [N];
	logic [N-1:0] acc_in [N];
	logic [D-1:0] dvs_in [N];
	logic [D:0]   trial  [N];
	logic [D:0]   diff   [N];

	always_comb begin
		rem_in[0] = '0;
		acc_in[0] = dividend;
		dvs_in[0] = divisor;
		for (int i = 1; i < N; i++) begin
			rem_in[i] = rem_s[i-1];
			acc_in[i] = acc_s[i-1];
			dvs_in[i] = dvs_s[i-1];
		end
		for (int i = 0; i < N; i++) begin
			trial[i] = {rem_in[i], acc_in[i][N-1]};
			diff[i]  = trial[i] - {1'b0, dvs_in[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				dvs_s[i] <= dvs_in[i];
				if (!diff[i][D]) begin
					rem_s[i] <= diff[i][D-1:0];
					acc_s[i] <= {acc_in[i][N-2:0], 1'b1};
				end else begin
					rem_s[i] <= trial[i][D-1:0];
					acc_s[i] <= {acc_in[i][N-2:0], 1'b0};
				end
			end
		end
	end

	assign quo = acc_s[N-1];
	assign rem = rem_s[N-1];

endmodule
`default_nettype wire

// ===== rtl/ptg_fifo.sv =====
`default_nettype none
module ptg_fifo
	import ptg_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic      [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q != '0)
		else $error("pushed request lost");

endmodule
`default_nettype wire

// ===== rtl/ptg_front.sv =====
`default_nettype none
module ptg_front
	import ptg_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [RES_W-1:0]       resolution,
	input  wire logic [IDX_W-1:0]       tile_index,
	output logic                        q_valid,
	input  wire logic                   q_ready,
	output logic [1+ZOOM_W+IDX_W+2*DIM_BITS-1:0] q_data,
	output logic      [TILE_W_BITS-1:0] tile_w_eff,
	output logic      [TILE_W_BITS-1:0] tile_h_eff,
	output logic      [DIM_BITS-1:0]    origin_x,
	output logic      [DIM_BITS-1:0]    origin_y
);

	localparam int CW = (DIM_BITS > TILE_W_BITS) ? DIM_BITS : TILE_W_BITS;

	logic [DIM_BITS-1:0]    image_width_q, image_height_q, origin_x_q, origin_y_q;
	logic [TILE_W_BITS-1:0] tile_w_q, tile_h_q;
	logic [ZOOM_W-1:0]      zbase_q, zbase_d;

	logic                   valid_s1;
	logic [RES_W-1:0]       res_s1;
	logic [IDX_W-1:0]       tile_s1;

	logic                   bad_res;
	logic [ZOOM_W-1:0]      zoom;
	logic [DIM_BITS-1:0]    lw, lh;

	assign cfg_ready  = 1'b1;
	assign tile_w_eff = (tile_w_q == '0) ? TILE_W_BITS'(1) : tile_w_q;
	assign tile_h_eff = (tile_h_q == '0) ? TILE_W_BITS'(1) : tile_h_q;
	assign origin_x   = origin_x_q;
	assign origin_y   = origin_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_BITS'(1);
			image_height_q <= DIM_BITS'(1);
			tile_w_q       <= TILE_RESET;
			tile_h_q       <= TILE_RESET;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[DIM_BITS-1:0];
				REG_TILE_W:       tile_w_q       <= cfg_data[TILE_W_BITS-1:0];
				REG_TILE_H:       tile_h_q       <= cfg_data[TILE_W_BITS-1:0];
				REG_ORIGIN_X:     origin_x_q     <= cfg_data[DIM_BITS-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= cfg_data[DIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// top zoom: first halving count at which both sides fit one tile
	always_comb begin
		zbase_d = ZOOM_W'(DIM_BITS);
		for (int k = DIM_BITS; k >= 0; k--) begin
			if ((CW'(image_width_q >> k) <= CW'(tile_w_eff)) &&
			    (CW'(image_height_q >> k) <= CW'(tile_h_eff))) begin
				zbase_d = ZOOM_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zbase_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			zbase_q <= zbase_d;
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			res_s1  <= resolution;
			tile_s1 <= tile_index;
		end
	end

	assign bad_res  = (res_s1 > zbase_q);
	assign zoom     = zbase_q - res_s1;
	assign lw       = image_width_q >> zoom;
	assign lh       = image_height_q >> zoom;
	assign q_valid  = valid_s1;
	assign q_data   = {bad_res, zoom, tile_s1, lh, lw};
	assign s_tready = !valid_s1 || q_ready;

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !q_ready |=> valid_s1 && $stable(tile_s1) && $stable(res_s1))
		else $error("front request dropped while queue full");

endmodule
`default_nettype wire

// ===== rtl/ptg_back.sv =====
`default_nettype none
module ptg_back
	import ptg_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_valid,
	output logic                        q_ready,
	input  wire logic [1+ZOOM_W+IDX_W+2*DIM_BITS-1:0] q_data,
	input  wire logic [TILE_W_BITS-1:0] tile_w_eff,
	input  wire logic [TILE_W_BITS-1:0] tile_h_eff,
	input  wire logic [DIM_BITS-1:0]    origin_x,
	input  wire logic [DIM_BITS-1:0]    origin_y,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [ST_W-1:0]        status,
	output logic      [TILE_W_BITS-1:0] out_tile_w,
	output logic      [TILE_W_BITS-1:0] out_tile_h,
	output logic      [POS_W-1:0]       pos_x,
	output logic      [POS_W-1:0]       pos_y,
	output logic      [ZOOM_W-1:0]      level_zoom
);

	localparam int QW = 1 + ZOOM_W + IDX_W + 2 * DIM_BITS;
	localparam int L1 = DIM_BITS;
	localparam int L2 = IDX_W;

	logic adv, pop;

	logic                   in_bad;
	logic [ZOOM_W-1:0]      in_zoom;
	logic [IDX_W-1:0]       in_tile;
	logic [DIM_BITS-1:0]    in_lw, in_lh;

	// level size / tile size
	logic [DIM_BITS-1:0]    qx, qy;
	logic [TILE_W_BITS-1:0] rx, ry;
	logic                   v1_s    [L1];
	logic                   bad1_s  [L1];
	logic [ZOOM_W-1:0]      zoom1_s [L1];
	logic [IDX_W-1:0]       tile1_s [L1];

	logic                   v_s1, bad_s1;
	logic [ZOOM_W-1:0]      zoom_s1;
	logic [IDX_W-1:0]       tile_s1;
	logic [DIM_BITS-1:0]    nx_s1, ny_s1;
	logic [TILE_W_BITS-1:0] rx_s1, ry_s1;

	// tile index / column count
	logic [IDX_W-1:0]       row;
	logic [DIM_BITS-1:0]    col;
	logic                   v2_s    [L2];
	logic                   bad2_s  [L2];
	logic [ZOOM_W-1:0]      zoom2_s [L2];
	logic [DIM_BITS-1:0]    nx2_s   [L2];
	logic [DIM_BITS-1:0]    ny2_s   [L2];
	logic [TILE_W_BITS-1:0] rx2_s   [L2];
	logic [TILE_W_BITS-1:0] ry2_s   [L2];

	logic [DIM_BITS-1:0]    nx2, ny2;
	logic [TILE_W_BITS-1:0] rx2, ry2;
	status_t                st_d;
	logic [TILE_W_BITS-1:0] ow_d, oh_d;

	logic                   v_s2;
	status_t                st_s2;
	logic [TILE_W_BITS-1:0] ow_s2, oh_s2;
	logic [DIM_BITS-1:0]    col_s2, row_s2;
	logic [ZOOM_W-1:0]      zoom_s2;

	logic                   v_s3;
	status_t                st_s3;
	logic [TILE_W_BITS-1:0] ow_s3, oh_s3;
	logic [POS_W-1:0]       prod_x_s3, prod_y_s3;
	logic [ZOOM_W-1:0]      zoom_s3;

	logic [POS_W-1:0]       sh_x, sh_y;
	logic [POS_W-1:0]       px_d, py_d;
	logic [TILE_W_BITS-1:0] tw_d, th_d;
	logic [ZOOM_W-1:0]      z_d;

	logic                   out_valid_q;
	status_t                out_st_q;
	logic [TILE_W_BITS-1:0] out_tw_q, out_th_q;
	logic [POS_W-1:0]       out_px_q, out_py_q;
	logic [ZOOM_W-1:0]      out_zoom_q;

	assign adv     = !out_valid_q || out_ready;
	assign q_ready = adv;
	assign pop     = q_valid && adv;

	assign in_lw   = q_data[DIM_BITS-1:0];
	assign in_lh   = q_data[2*DIM_BITS-1:DIM_BITS];
	assign in_tile = q_data[2*DIM_BITS +: IDX_W];
	assign in_zoom = q_data[2*DIM_BITS+IDX_W +: ZOOM_W];
	assign in_bad  = q_data[QW-1];

	ptg_div #(.N(DIM_BITS), .D(TILE_W_BITS)) u_div_x (
		.clk      (clk),
		.en       (adv),
		.dividend (in_lw),
		.divisor  (tile_w_eff),
		.quo      (qx),
		.rem      (rx)
	);

	ptg_div #(.N(DIM_BITS), .D(TILE_W_BITS)) u_div_y (
		.clk      (clk),
		.en       (adv),
		.dividend (in_lh),
		.divisor  (tile_h_eff),
		.quo      (qy),
		.rem      (ry)
	);

	ptg_div #(.N(IDX_W), .D(DIM_BITS)) u_div_idx (
		.clk      (clk),
		.en       (adv),
		.dividend (tile_s1),
		.divisor  (nx_s1),
		.quo      (row),
		.rem      (col)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < L1; i++) v1_s[i] <= 1'b0;
			for (int i = 0; i < L2; i++) v2_s[i] <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v1_s[0] <= pop;
			for (int i = 1; i < L1; i++) v1_s[i] <= v1_s[i-1];
			v_s1    <= v1_s[L1-1];
			v2_s[0] <= v_s1;
			for (int i = 1; i < L2; i++) v2_s[i] <= v2_s[i-1];
			v_s2        <= v2_s[L2-1];
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	assign nx2 = nx2_s[L2-1];
	assign ny2 = ny2_s[L2-1];
	assign rx2 = rx2_s[L2-1];
	assign ry2 = ry2_s[L2-1];

	always_comb begin
		if (bad2_s[L2-1]) begin
			st_d = ST_BAD_RES;
		end else if (nx2 == '0 || ny2 == '0 || row >= IDX_W'(ny2)) begin
			st_d = ST_BAD_TILE;
		end else begin
			st_d = ST_OK;
		end
		ow_d = (col == nx2 - DIM_BITS'(1) && rx2 != '0) ? rx2 : tile_w_eff;
		oh_d = (row[DIM_BITS-1:0] == ny2 - DIM_BITS'(1) && ry2 != '0) ? ry2 : tile_h_eff;
	end

	always_comb begin
		sh_x = prod_x_s3 << zoom_s3;
		sh_y = prod_y_s3 << zoom_s3;
		px_d = '0;
		py_d = '0;
		tw_d = '0;
		th_d = '0;
		z_d  = '0;
		case (st_s3)
			ST_OK: begin
				px_d = sh_x + POS_W'(origin_x);
				py_d = sh_y + POS_W'(origin_y);
				tw_d = ow_s3;
				th_d = oh_s3;
				z_d  = zoom_s3;
			end
			ST_BAD_TILE: begin
				z_d = zoom_s3;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			bad1_s[0]  <= in_bad;
			zoom1_s[0] <= in_zoom;
			tile1_s[0] <= in_tile;
			for (int i = 1; i < L1; i++) begin
				bad1_s[i]  <= bad1_s[i-1];
				zoom1_s[i] <= zoom1_s[i-1];
				tile1_s[i] <= tile1_s[i-1];
			end

			bad_s1  <= bad1_s[L1-1];
			zoom_s1 <= zoom1_s[L1-1];
			tile_s1 <= tile1_s[L1-1];
			nx_s1   <= qx + DIM_BITS'(rx != '0);
			ny_s1   <= qy + DIM_BITS'(ry != '0);
			rx_s1   <= rx;
			ry_s1   <= ry;

			bad2_s[0]  <= bad_s1;
			zoom2_s[0] <= zoom_s1;
			nx2_s[0]   <= nx_s1;
			ny2_s[0]   <= ny_s1;
			rx2_s[0]   <= rx_s1;
			ry2_s[0]   <= ry_s1;
			for (int i = 1; i < L2; i++) begin
				bad2_s[i]  <= bad2_s[i-1];
				zoom2_s[i] <= zoom2_s[i-1];
				nx2_s[i]   <= nx2_s[i-1];
				ny2_s[i]   <= ny2_s[i-1];
				rx2_s[i]   <= rx2_s[i-1];
				ry2_s[i]   <= ry2_s[i-1];
			end

			st_s2   <= st_d;
			ow_s2   <= ow_d;
			oh_s2   <= oh_d;
			col_s2  <= col;
			row_s2  <= row[DIM_BITS-1:0];
			zoom_s2 <= zoom2_s[L2-1];

			st_s3     <= st_s2;
			ow_s3     <= ow_s2;
			oh_s3     <= oh_s2;
			prod_x_s3 <= POS_W'(col_s2) * POS_W'(tile_w_eff);
			prod_y_s3 <= POS_W'(row_s2) * POS_W'(tile_h_eff);
			zoom_s3   <= zoom_s2;

			out_st_q   <= st_s3;
			out_tw_q   <= tw_d;
			out_th_q   <= th_d;
			out_px_q   <= px_d;
			out_py_q   <= py_d;
			out_zoom_q <= z_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign out_tile_w = out_tw_q;
	assign out_tile_h = out_th_q;
	assign pos_x      = out_px_q;
	assign pos_y      = out_py_q;
	assign level_zoom = out_zoom_q;

	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == ST_OK |->
			out_tw_q != '0 && out_th_q != '0 &&
			out_tw_q <= tile_w_eff && out_th_q <= tile_h_eff)
		else $error("accepted tile has bad clipped size");

	a_bad_res_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q == ST_BAD_RES |->
			out_zoom_q == '0 && out_px_q == '0 && out_py_q == '0)
		else $error("resolution reject carries data");

endmodule
`default_nettype wire

// ===== rtl/pyramid_tile_geometry.sv =====
`default_nettype none
// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_index (register), cfg_data
// s         in         s_tvalid/s_tready    s_tdata: resolution, tile_index
// m         out        m_tvalid/m_tready    m_tuser: status; m_tdata: tile size, origin, zoom
//
// One request per cycle sustained while m_tready is high; divides are restoring, one bit per stage.
// Requests pass a front register, then the queue, then DIM_BITS + 36 back stages.
// The back pipeline freezes only while a result sits unaccepted on m.
// The front keeps taking requests until the queue is full.
// arst_n clears control state and loads the register reset values.
module pyramid_tile_geometry
	import ptg_pkg::*;
#(
	parameter int DIM_BITS = DIM_BITS_DEF,
	parameter int Q_DEPTH  = Q_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // resolution[4:0], tile_index[36:5]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [M_TDATA_W-1:0]  m_tdata,   // out_tile_w, out_tile_h, pos_x, pos_y, level_zoom
	output logic      [ST_W-1:0]       m_tuser    // status
);

	localparam int QW = 1 + ZOOM_W + IDX_W + 2 * DIM_BITS;

	logic                   q_in_valid, q_in_ready, q_out_valid, q_out_ready;
	logic [QW-1:0]          q_in_data, q_out_data;
	logic [TILE_W_BITS-1:0] tile_w_eff, tile_h_eff;
	logic [DIM_BITS-1:0]    origin_x, origin_y;

	logic [TILE_W_BITS-1:0] out_tile_w, out_tile_h;
	logic [POS_W-1:0]       pos_x, pos_y;
	logic [ZOOM_W-1:0]      level_zoom;

	ptg_front #(.DIM_BITS(DIM_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.resolution (s_tdata[RES_W-1:0]),
		.tile_index (s_tdata[RES_W +: IDX_W]),
		.q_valid    (q_in_valid),
		.q_ready    (q_in_ready),
		.q_data     (q_in_data),
		.tile_w_eff (tile_w_eff),
		.tile_h_eff (tile_h_eff),
		.origin_x   (origin_x),
		.origin_y   (origin_y)
	);

	ptg_fifo #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_in_valid),
		.wr_ready (q_in_ready),
		.wr_data  (q_in_data),
		.rd_valid (q_out_valid),
		.rd_ready (q_out_ready),
		.rd_data  (q_out_data)
	);

	ptg_back #(.DIM_BITS(DIM_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_out_valid),
		.q_ready    (q_out_ready),
		.q_data     (q_out_data),
		.tile_w_eff (tile_w_eff),
		.tile_h_eff (tile_h_eff),
		.origin_x   (origin_x),
		.origin_y   (origin_y),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.status     (m_tuser),
		.out_tile_w (out_tile_w),
		.out_tile_h (out_tile_h),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.level_zoom (level_zoom)
	);

	assign m_tdata = {{M_PAD_W{1'b0}}, level_zoom, pos_y, pos_x, out_tile_h, out_tile_w};

endmodule
`default_nettype wire
